// ===== sv/tle_pkg.sv =====
// ----------------------------------------------------------------------------
// tle_pkg: shared types and constants
// Sizes, result kinds, key codes and FSM states for the line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

  localparam int LINE_BYTES       = 64;
  localparam int HIST_DEPTH       = 8;
  localparam int HIST_ENTRY_BYTES = 64;

  localparam int LW  = $clog2(LINE_BYTES);                      // line length / index
  localparam int HSW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1; // slot number
  localparam int HCW = $clog2(HIST_DEPTH + 1);                   // entry count
  localparam int HLW = $clog2(HIST_ENTRY_BYTES);                 // stored entry length
  localparam int HAW = $clog2(HIST_DEPTH * HIST_ENTRY_BYTES);    // history address

  localparam logic [0:0] CFG_HISTORY_ON    = 1'b0;
  localparam logic [0:0] CFG_HISTORY_SLOTS = 1'b1;

  typedef enum logic [2:0] {
    KIND_REDRAW_CHR = 3'd0,
    KIND_REDRAW_END = 3'd1,
    KIND_LINE_CHR   = 3'd2,
    KIND_LINE_DONE  = 3'd3,
    KIND_INTR       = 3'd4
  } kind_e;

  localparam logic [7:0] KEY_CTRL_C = 8'h03;
  localparam logic [7:0] KEY_BS     = 8'h08;
  localparam logic [7:0] KEY_LF     = 8'h0A;
  localparam logic [7:0] CTL_UP     = 8'h10;
  localparam logic [7:0] CTL_DOWN   = 8'h11;
  localparam logic [7:0] CTL_LEFT   = 8'h12;
  localparam logic [7:0] CTL_RIGHT  = 8'h13;
  localparam logic [7:0] CTL_HOME   = 8'h14;
  localparam logic [7:0] CTL_END    = 8'h15;
  localparam logic [7:0] KEY_DEL    = 8'h16;
  localparam logic [7:0] KEY_ESC    = 8'h1B;
  localparam logic [7:0] KEY_SPACE  = 8'h20;
  localparam logic [7:0] KEY_RUB    = 8'h7F;
  localparam logic [7:0] KEY_LBRK   = 8'h5B;
  localparam logic [7:0] KEY_ZERO   = 8'h30;
  localparam logic [7:0] KEY_NINE   = 8'h39;
  localparam logic [7:0] KEY_THREE  = 8'h33;
  localparam logic [7:0] FIN_LO     = 8'h40;
  localparam logic [7:0] FIN_HI     = 8'h7E;
  localparam logic [7:0] FIN_TILDE  = 8'h7E;
  localparam logic [7:0] FIN_UP     = 8'h41;
  localparam logic [7:0] FIN_DOWN   = 8'h42;
  localparam logic [7:0] FIN_RIGHT  = 8'h43;
  localparam logic [7:0] FIN_LEFT   = 8'h44;
  localparam logic [7:0] FIN_END    = 8'h46;
  localparam logic [7:0] FIN_HOME   = 8'h48;

  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_SEEN = 2'd1;
  localparam logic [1:0] ESC_CSI  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_END,
    ST_INTR,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_PUSH_GO,
    ST_PUSH_RD,
    ST_PUSH_WR,
    ST_LOAD_RD,
    ST_LOAD_WR
  } state_e;

  // (head + offset) mod slots, with the sum known to stay below twice slots
  function automatic logic [HSW-1:0] mod_slot(input logic [HCW:0] sum,
                                               input logic [HCW-1:0] s);
    logic [HCW:0] r;
    r = (sum >= {1'b0, s}) ? sum - {1'b0, s} : sum;
    return r[HSW-1:0];
  endfunction

  function automatic logic [HAW-1:0] hist_addr(input logic [HSW-1:0] slot,
                                               input logic [LW-1:0] idx);
    return HAW'(slot) * HAW'(HIST_ENTRY_BYTES) + HAW'(idx);
  endfunction

endpackage

// ===== sv/tle_key_if.sv =====
// ----------------------------------------------------------------------------
// tle_key_if: keyboard byte channel
// valid/ready channel carrying one received key byte per word.
// ----------------------------------------------------------------------------
interface tle_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;

  modport source (output valid, output key_byte, input ready);
  modport sink   (input valid, input key_byte, output ready);
endinterface

// ===== sv/tle_res_if.sv =====
// ----------------------------------------------------------------------------
// tle_res_if: editor result channel
// valid/ready channel carrying one redraw or line result per word.
// ----------------------------------------------------------------------------
interface tle_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_kind;
  logic [7:0] out_char;
  logic [5:0] cursor_back;
  logic [5:0] line_length;
  logic       out_last;

  modport source (output valid, output out_kind, output out_char, output cursor_back,
                  output line_length, output out_last, input ready);
  modport sink   (input valid, input out_kind, input out_char, input cursor_back,
                  input line_length, input out_last, output ready);
endinterface

// ===== sv/tle_ram.sv =====
// ----------------------------------------------------------------------------
// tle_ram: generic single-port-write RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== sv/terminal_line_editor_history.sv =====
// ----------------------------------------------------------------------------
// terminal_line_editor_history: escape-aware line editor with history ring
// Parses key bytes, edits a line held in RAM and replays it as result words.
// ----------------------------------------------------------------------------
// Timing: a byte that edits nothing is handled in idle; shift, redraw, history load,
//   duplicate check and push each walk the RAMs one character per read/write state
//   pair, and any result word waits while the result side stalls.
// Throughput: one byte at a time; key ready is high only while the sequencer idles.
// Reset: async active low; line empty, escape parser idle, history empty,
//   history_on = 1, history_slots = 8. RAM contents are not cleared.
module terminal_line_editor_history
  import tle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tle_key_if.sink    key_i,
  tle_res_if.source  res_o,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [3:0] cfg_data_i
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e          state_q, state_d;
  logic [1:0]      esc_q, esc_d;
  logic [7:0]      csi_cnt_q, csi_cnt_d;
  logic [7:0]      csi_last_q, csi_last_d;
  logic [LW-1:0]   len_q, len_d;       // line length
  logic [LW-1:0]   cur_q, cur_d;       // cursor column
  logic [LW-1:0]   idx_q, idx_d;       // walk index of the sequencer
  logic [LW-1:0]   tgt_q, tgt_d;       // history load length
  logic [HSW-1:0]  head_q, head_d;
  logic [HCW-1:0]  hcnt_q, hcnt_d;
  logic [HCW-1:0]  bidx_q, bidx_d;
  logic            brw_q, brw_d;
  logic            on_q, on_d;
  logic [3:0]      slots_q, slots_d;
  logic [HSW-1:0]  slot_q, slot_d;     // history slot being read or written
  logic [7:0]      chr_q, chr_d;       // byte to insert
  logic            ins_q, ins_d;       // shift direction: 1 insert, 0 delete
  logic            enter_q, enter_d;   // emitting a finished line

  // output word register
  logic            ov_q, ov_d;
  kind_e           okind_q, okind_d;
  logic [7:0]      ochar_q, ochar_d;
  logic [5:0]      oback_q, oback_d;
  logic [5:0]      olen_q, olen_d;
  logic            olast_q, olast_d;

  logic [HLW-1:0]  hlen_q [HIST_DEPTH];  // stored entry lengths, written before read
  logic            hl_we;

  // RAM ports
  logic            l_we;
  logic [LW-1:0]   l_waddr, l_raddr;
  logic [7:0]      l_wdata, l_rdata;
  logic            h_we;
  logic [HAW-1:0]  h_waddr, h_raddr;
  logic [7:0]      h_wdata, h_rdata;

  tle_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  tle_ram #(.WIDTH(8), .DEPTH(HIST_DEPTH * HIST_ENTRY_BYTES)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  // effective ring size: 0 acts as 1, above the depth acts as the depth
  logic [7:0]     s8;
  logic [HCW-1:0] s_eff;
  always_comb begin
    if (slots_q == 4'd0) begin
      s8 = 8'd1;
    end else if (8'(slots_q) > 8'(HIST_DEPTH)) begin
      s8 = 8'(HIST_DEPTH);
    end else begin
      s8 = 8'(slots_q);
    end
  end
  assign s_eff = s8[HCW-1:0];

  wire can_load = !ov_q || res_o.ready;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [7:0]     c;
  logic           fin_go;
  logic [7:0]     fin;
  logic [7:0]     n_eff;
  logic [11:0]    dig_v;
  logic [HCW-1:0] bnew;
  logic [HSW-1:0] lslot;
  logic [LW:0]    idx_p1;
  logic [HLW:0]   lraw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      esc_q      <= ESC_IDLE;
      csi_cnt_q  <= '0;
      csi_last_q <= '0;
      len_q      <= '0;
      cur_q      <= '0;
      idx_q      <= '0;
      tgt_q      <= '0;
      head_q     <= '0;
      hcnt_q     <= '0;
      bidx_q     <= '0;
      brw_q      <= 1'b0;
      on_q       <= 1'b1;
      slots_q    <= 4'd8;
      slot_q     <= '0;
      ins_q      <= 1'b0;
      enter_q    <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      esc_q      <= esc_d;
      csi_cnt_q  <= csi_cnt_d;
      csi_last_q <= csi_last_d;
      len_q      <= len_d;
      cur_q      <= cur_d;
      idx_q      <= idx_d;
      tgt_q      <= tgt_d;
      head_q     <= head_d;
      hcnt_q     <= hcnt_d;
      bidx_q     <= bidx_d;
      brw_q      <= brw_d;
      on_q       <= on_d;
      slots_q    <= slots_d;
      slot_q     <= slot_d;
      ins_q      <= ins_d;
      enter_q    <= enter_d;
      ov_q       <= ov_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    chr_q   <= chr_d;
    okind_q <= okind_d;
    ochar_q <= ochar_d;
    oback_q <= oback_d;
    olen_q  <= olen_d;
    olast_q <= olast_d;
    if (hl_we) begin
      hlen_q[slot_q] <= HLW'(len_q);
    end
  end

  always_comb begin
    state_d    = state_q;
    esc_d      = esc_q;
    csi_cnt_d  = csi_cnt_q;
    csi_last_d = csi_last_q;
    len_d      = len_q;
    cur_d      = cur_q;
    idx_d      = idx_q;
    tgt_d      = tgt_q;
    head_d     = head_q;
    hcnt_d     = hcnt_q;
    bidx_d     = bidx_q;
    brw_d      = brw_q;
    on_d       = on_q;
    slots_d    = slots_q;
    slot_d     = slot_q;
    chr_d      = chr_q;
    ins_d      = ins_q;
    enter_d    = enter_q;
    ov_d       = ov_q && !res_o.ready;
    okind_d    = okind_q;
    ochar_d    = ochar_q;
    oback_d    = oback_q;
    olen_d     = olen_q;
    olast_d    = olast_q;
    hl_we      = 1'b0;
    l_we       = 1'b0;
    l_waddr    = idx_q;
    l_wdata    = l_rdata;
    l_raddr    = idx_q;
    h_we       = 1'b0;
    h_waddr    = hist_addr(slot_q, idx_q);
    h_wdata    = l_rdata;
    h_raddr    = hist_addr(slot_q, idx_q);
    c          = key_i.key_byte;
    fin_go     = 1'b0;
    fin        = '0;
    n_eff      = '0;
    dig_v      = '0;
    bnew       = '0;
    lslot      = '0;
    idx_p1     = {1'b0, idx_q} + 1'b1;
    lraw       = '0;
    key_i.ready = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (key_i.valid) begin
          // ---- byte decode ----
          if (esc_q == ESC_SEEN) begin
            if (c == KEY_LBRK) begin
              esc_d      = ESC_CSI;
              csi_cnt_d  = '0;
              csi_last_d = '0;
            end else begin
              esc_d = ESC_IDLE;
            end
          end else if (esc_q == ESC_CSI) begin
            if (c >= KEY_ZERO && c <= KEY_NINE) begin
              dig_v      = 12'(csi_cnt_q) * 12'd10 + 12'(c - KEY_ZERO);
              csi_cnt_d  = (dig_v > 12'd255) ? 8'd255 : dig_v[7:0];
              csi_last_d = c;
            end else begin
              esc_d = ESC_IDLE;
              if (c >= FIN_LO && c <= FIN_HI) begin
                fin_go = 1'b1;
                fin    = c;
              end
            end
          end else begin
            esc_d = ESC_IDLE;
            unique case (c) inside
              KEY_ESC: esc_d = ESC_SEEN;
              KEY_CTRL_C: begin
                len_d  = '0;
                cur_d  = '0;
                brw_d  = 1'b0;
                bidx_d = '0;
                state_d = ST_INTR;
              end
              KEY_LF: begin
                enter_d = 1'b1;
                idx_d   = '0;
                state_d = ST_EMIT_RD;
              end
              KEY_BS, KEY_RUB: begin
                if (cur_q != '0) begin
                  cur_d   = cur_q - 1'b1;
                  idx_d   = cur_q - 1'b1;
                  ins_d   = 1'b0;
                  enter_d = 1'b0;
                  state_d = ST_SHIFT_RD;
                end
              end
              CTL_UP:    begin fin_go = 1'b1; fin = FIN_UP;   end
              CTL_DOWN:  begin fin_go = 1'b1; fin = FIN_DOWN; end
              CTL_LEFT:  begin fin_go = 1'b1; fin = FIN_LEFT;  csi_cnt_d = '0; end
              CTL_RIGHT: begin fin_go = 1'b1; fin = FIN_RIGHT; csi_cnt_d = '0; end
              CTL_HOME:  begin fin_go = 1'b1; fin = FIN_HOME; end
              CTL_END:   begin fin_go = 1'b1; fin = FIN_END;  end
              KEY_DEL: begin
                if (cur_q < len_q) begin
                  idx_d   = cur_q;
                  ins_d   = 1'b0;
                  enter_d = 1'b0;
                  state_d = ST_SHIFT_RD;
                end
              end
              default: begin
                // printable: insert when there is room
                if (c >= KEY_SPACE && {1'b0, len_q} < (LW + 1)'(LINE_BYTES - 1)) begin
                  chr_d   = c;
                  idx_d   = len_q;
                  ins_d   = 1'b1;
                  enter_d = 1'b0;
                  state_d = ST_SHIFT_RD;
                end
              end
            endcase
          end

          // ---- final byte actions ----
          if (fin_go) begin
            enter_d = 1'b0;
            n_eff   = (csi_cnt_d == 8'd0) ? 8'd1 : csi_cnt_d;
            case (fin)
              FIN_TILDE: begin
                if (csi_last_q == KEY_THREE && cur_q < len_q) begin
                  idx_d   = cur_q;
                  ins_d   = 1'b0;
                  state_d = ST_SHIFT_RD;
                end
              end
              FIN_UP: begin
                if (on_q && hcnt_q != '0) begin
                  bnew  = brw_q ? bidx_q : hcnt_q;
                  brw_d = 1'b1;
                  if (bnew != '0) begin
                    bidx_d = bnew - 1'b1;
                    lslot  = mod_slot({1'b0, head_q} + (HCW + 1)'(bnew - 1'b1), s_eff);
                    slot_d = lslot;
                    lraw   = {1'b0, hlen_q[lslot]};
                    tgt_d  = (lraw > (HLW + 1)'(LINE_BYTES - 1)) ?
                             LW'(LINE_BYTES - 1) : LW'(lraw);
                    idx_d  = '0;
                    state_d = ST_LOAD_RD;
                  end else begin
                    bidx_d = bnew;
                  end
                end
              end
              FIN_DOWN: begin
                if (on_q && brw_q) begin
                  bnew = bidx_q + 1'b1;
                  if (bnew >= hcnt_q) begin
                    brw_d  = 1'b0;
                    bidx_d = '0;
                    len_d  = '0;
                    cur_d  = '0;
                    idx_d  = '0;
                    state_d = ST_EMIT_RD;
                  end else begin
                    bidx_d = bnew;
                    lslot  = mod_slot({1'b0, head_q} + (HCW + 1)'(bnew), s_eff);
                    slot_d = lslot;
                    lraw   = {1'b0, hlen_q[lslot]};
                    tgt_d  = (lraw > (HLW + 1)'(LINE_BYTES - 1)) ?
                             LW'(LINE_BYTES - 1) : LW'(lraw);
                    idx_d  = '0;
                    state_d = ST_LOAD_RD;
                  end
                end
              end
              FIN_LEFT: begin
                if (cur_q != '0) begin
                  cur_d   = (n_eff >= 8'(cur_q)) ? '0 : cur_q - LW'(n_eff);
                  idx_d   = '0;
                  state_d = ST_EMIT_RD;
                end
              end
              FIN_RIGHT: begin
                if (cur_q < len_q) begin
                  cur_d   = (n_eff >= 8'(len_q - cur_q)) ? len_q : cur_q + LW'(n_eff);
                  idx_d   = '0;
                  state_d = ST_EMIT_RD;
                end
              end
              FIN_HOME: begin
                if (cur_q != '0) begin
                  cur_d   = '0;
                  idx_d   = '0;
                  state_d = ST_EMIT_RD;
                end
              end
              FIN_END: begin
                if (cur_q < len_q) begin
                  cur_d   = len_q;
                  idx_d   = '0;
                  state_d = ST_EMIT_RD;
                end
              end
              default: ;
            endcase
          end
        end
      end

      // move one character per read/write pair
      ST_SHIFT_RD: begin
        if (ins_q) begin
          if (idx_q == cur_q) begin
            l_we    = 1'b1;
            l_waddr = cur_q;
            l_wdata = chr_q;
            len_d   = len_q + 1'b1;
            cur_d   = cur_q + 1'b1;
            idx_d   = '0;
            state_d = ST_EMIT_RD;
          end else begin
            l_raddr = idx_q - 1'b1;
            state_d = ST_SHIFT_WR;
          end
        end else begin
          if (idx_p1 >= {1'b0, len_q}) begin
            len_d   = len_q - 1'b1;
            idx_d   = '0;
            state_d = ST_EMIT_RD;
          end else begin
            l_raddr = idx_p1[LW-1:0];
            state_d = ST_SHIFT_WR;
          end
        end
      end

      ST_SHIFT_WR: begin
        l_we    = 1'b1;
        l_waddr = idx_q;
        idx_d   = ins_q ? idx_q - 1'b1 : idx_q + 1'b1;
        state_d = ST_SHIFT_RD;
      end

      // replay the line, one word per character
      ST_EMIT_RD: begin
        state_d = (idx_q == len_q) ? ST_END : ST_EMIT_WR;
      end

      ST_EMIT_WR: begin
        if (can_load) begin
          ov_d    = 1'b1;
          okind_d = enter_q ? KIND_LINE_CHR : KIND_REDRAW_CHR;
          ochar_d = l_rdata;
          oback_d = '0;
          olen_d  = 6'(len_q);
          olast_d = 1'b0;
          idx_d   = idx_q + 1'b1;
          state_d = ST_EMIT_RD;
        end
      end

      ST_END: begin
        if (can_load) begin
          ov_d    = 1'b1;
          okind_d = enter_q ? KIND_LINE_DONE : KIND_REDRAW_END;
          ochar_d = '0;
          oback_d = enter_q ? 6'd0 : 6'(len_q - cur_q);
          olen_d  = 6'(len_q);
          olast_d = 1'b1;
          idx_d   = '0;
          state_d = ST_IDLE;
          if (enter_q) begin
            if (on_q && len_q != '0 && 8'(len_q) < 8'(HIST_ENTRY_BYTES)) begin
              if (hcnt_q != '0) begin
                lslot  = mod_slot({1'b0, head_q} + (HCW + 1)'(hcnt_q - 1'b1), s_eff);
                slot_d = lslot;
                state_d = (8'(hlen_q[lslot]) == 8'(len_q)) ? ST_CMP_RD : ST_PUSH_GO;
              end else begin
                state_d = ST_PUSH_GO;
              end
            end else begin
              len_d  = '0;
              cur_d  = '0;
              brw_d  = 1'b0;
              bidx_d = '0;
            end
          end
        end
      end

      ST_INTR: begin
        if (can_load) begin
          ov_d    = 1'b1;
          okind_d = KIND_INTR;
          ochar_d = '0;
          oback_d = '0;
          olen_d  = '0;
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end

      // duplicate check against the newest entry
      ST_CMP_RD: begin
        if (idx_q == len_q) begin
          // same line already newest: skip the push
          len_d   = '0;
          cur_d   = '0;
          brw_d   = 1'b0;
          bidx_d  = '0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_CMP_CHK;
        end
      end

      ST_CMP_CHK: begin
        if (l_rdata != h_rdata) begin
          state_d = ST_PUSH_GO;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_CMP_RD;
        end
      end

      ST_PUSH_GO: begin
        if (hcnt_q < s_eff) begin
          slot_d = mod_slot({1'b0, head_q} + (HCW + 1)'(hcnt_q), s_eff);
          hcnt_d = hcnt_q + 1'b1;
        end else begin
          slot_d = head_q;
          head_d = mod_slot({1'b0, head_q} + (HCW + 1)'(1), s_eff);
        end
        idx_d   = '0;
        state_d = ST_PUSH_RD;
      end

      ST_PUSH_RD: begin
        if (idx_q == len_q) begin
          hl_we   = 1'b1;
          len_d   = '0;
          cur_d   = '0;
          brw_d   = 1'b0;
          bidx_d  = '0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_PUSH_WR;
        end
      end

      ST_PUSH_WR: begin
        h_we    = 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = ST_PUSH_RD;
      end

      // copy a history entry into the line
      ST_LOAD_RD: begin
        if (idx_q == tgt_q) begin
          len_d   = tgt_q;
          cur_d   = tgt_q;
          idx_d   = '0;
          state_d = ST_EMIT_RD;
        end else begin
          state_d = ST_LOAD_WR;
        end
      end

      ST_LOAD_WR: begin
        l_we    = 1'b1;
        l_wdata = h_rdata;
        idx_d   = idx_q + 1'b1;
        state_d = ST_LOAD_RD;
      end

      default: state_d = ST_IDLE;
    endcase

    // register writes reset the ring and end browsing
    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_HISTORY_ON) begin
        on_d = cfg_data_i[0];
      end else begin
        slots_d = cfg_data_i;
      end
      head_d = '0;
      hcnt_d = '0;
      brw_d  = 1'b0;
      bidx_d = '0;
    end
  end

  assign res_o.valid       = ov_q;
  assign res_o.out_kind    = okind_q;
  assign res_o.out_char    = ochar_q;
  assign res_o.cursor_back = oback_q;
  assign res_o.line_length = olen_q;
  assign res_o.out_last    = olast_q;

endmodule

// ===== tb/tb_terminal_line_editor_history.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_terminal_line_editor_history: self-checking bench for the line editor
// Drives key bytes in bursts, stalls the result side, predicts every result
// word from a local model of the editor and compares word by word.
// ----------------------------------------------------------------------------
module tb_terminal_line_editor_history
  import tle_pkg::*;
();

  localparam int CLK_HALF   = 4;
  localparam int IDLE_WAIT  = 500;     // idle wait after draining, covers a trailing duplicate check and push
  localparam int CYCLE_CAP  = 3000000;
  localparam int RAND_ITEMS = 420;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] chr;
    logic [5:0] back;
    logic [5:0] len;
    logic       last;
  } res_t;

  // directed row: key, number of words (-1: predictor only), kind/len of last word
  typedef struct {
    logic [7:0] key;
    int         nres;
    kind_e      kind;
    int         len;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic       cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [3:0] cfg_data_i;

  tle_key_if key_if ();
  tle_res_if res_if ();

  terminal_line_editor_history DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_i      (key_if.sink),
    .res_o      (res_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // bytes waiting to go out, expected result words, directed row checks
  logic [7:0] key_q[$];
  res_t       redraw_q[$];
  row_t       row_q[$];
  int         errors;
  int         cycles;
  int         words_rx;

  // ---------------------------------------------------------------------------
  // Editor model state
  // ---------------------------------------------------------------------------
  logic       hist_en;
  logic [3:0] hist_slots;
  logic [7:0] line_mem[LINE_BYTES];
  int         line_len, cur_pos;
  logic [1:0] esc_st;
  int         csi_num;
  logic [7:0] csi_digit;
  logic [7:0] hist_mem[HIST_DEPTH][HIST_ENTRY_BYTES];
  int         ent_len[HIST_DEPTH];
  int         ring_head, hist_cnt, walk_idx;
  logic       walking;
  int         words_out;   // words produced by the byte being modeled

  function automatic int slots_used();
    if (hist_slots == 0) return 1;
    if (hist_slots > HIST_DEPTH) return HIST_DEPTH;
    return int'(hist_slots);
  endfunction

  function automatic void emit(logic [2:0] kind, logic [7:0] chr, int back, int len);
    res_t r;
    r.kind = kind;
    r.chr  = chr;
    r.back = back[5:0];
    r.len  = len[5:0];
    r.last = 1'b0;
    redraw_q.push_back(r);
    words_out++;
  endfunction

  function automatic void redraw();
    for (int i = 0; i < line_len; i++) emit(KIND_REDRAW_CHR, line_mem[i], 0, line_len);
    emit(KIND_REDRAW_END, 8'h00, line_len - cur_pos, line_len);
  endfunction

  function automatic void cut_char();
    for (int i = cur_pos; i + 1 < line_len; i++) line_mem[i] = line_mem[i + 1];
    line_len--;
  endfunction

  function automatic void record_line();
    int s, slot, prev;
    bit same;
    s = slots_used();
    if (!hist_en || line_len == 0 || line_len >= HIST_ENTRY_BYTES) return;
    if (hist_cnt > 0) begin
      // consecutive duplicates are not stored again
      prev = (ring_head + hist_cnt - 1) % s;
      same = (ent_len[prev] == line_len);
      for (int i = 0; i < line_len && same; i++)
        if (hist_mem[prev][i] != line_mem[i]) same = 0;
      if (same) return;
    end
    if (hist_cnt < s) begin
      slot = (ring_head + hist_cnt) % s;
      hist_cnt++;
    end else begin
      slot = ring_head;
      ring_head = (ring_head + 1) % s;
    end
    for (int i = 0; i < line_len; i++) hist_mem[slot][i] = line_mem[i];
    ent_len[slot] = line_len;
  endfunction

  function automatic void recall_line();
    int slot, n;
    slot = (ring_head + walk_idx) % slots_used();
    n = ent_len[slot];
    if (n > LINE_BYTES - 1) n = LINE_BYTES - 1;
    for (int i = 0; i < n; i++) line_mem[i] = hist_mem[slot][i];
    line_len = n;
    cur_pos  = n;
    redraw();
  endfunction

  function automatic void run_final(logic [7:0] fin);
    int n;
    n = (csi_num > 0) ? csi_num : 1;
    case (fin)
      FIN_TILDE: begin
        if (csi_digit == KEY_THREE && cur_pos < line_len) begin
          cut_char();
          redraw();
        end
      end
      FIN_UP: begin
        if (hist_en && hist_cnt != 0) begin
          if (!walking) begin
            walking  = 1;
            walk_idx = hist_cnt;
          end
          if (walk_idx > 0) begin
            walk_idx--;
            recall_line();
          end
        end
      end
      FIN_DOWN: begin
        if (hist_en && walking) begin
          walk_idx++;
          if (walk_idx >= hist_cnt) begin
            // stepped past the newest entry: back to an empty line
            walking  = 0;
            walk_idx = 0;
            line_len = 0;
            cur_pos  = 0;
            redraw();
          end else begin
            recall_line();
          end
        end
      end
      FIN_LEFT: begin
        if (cur_pos != 0) begin
          cur_pos = (n >= cur_pos) ? 0 : cur_pos - n;
          redraw();
        end
      end
      FIN_RIGHT: begin
        if (cur_pos < line_len) begin
          cur_pos = (n >= line_len - cur_pos) ? line_len : cur_pos + n;
          redraw();
        end
      end
      FIN_HOME: begin
        if (cur_pos != 0) begin
          cur_pos = 0;
          redraw();
        end
      end
      FIN_END: begin
        if (cur_pos < line_len) begin
          cur_pos = line_len;
          redraw();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void clear_line();
    line_len = 0;
    cur_pos  = 0;
    walking  = 0;
    walk_idx = 0;
  endfunction

  function automatic void edit_byte(logic [7:0] c);
    if (esc_st == ESC_SEEN) begin
      if (c == KEY_LBRK) begin
        esc_st    = ESC_CSI;
        csi_num   = 0;
        csi_digit = 8'h00;
      end else begin
        esc_st = ESC_IDLE;
      end
      return;
    end
    if (esc_st == ESC_CSI) begin
      if (c >= KEY_ZERO && c <= KEY_NINE) begin
        csi_num   = csi_num * 10 + int'(c - KEY_ZERO);
        if (csi_num > 255) csi_num = 255;
        csi_digit = c;
        return;
      end
      esc_st = ESC_IDLE;
      if (c >= FIN_LO && c <= FIN_HI) run_final(c);
      return;
    end
    esc_st = ESC_IDLE;
    case (c) inside
      KEY_ESC: esc_st = ESC_SEEN;
      KEY_CTRL_C: begin
        clear_line();
        emit(KIND_INTR, 8'h00, 0, 0);
      end
      KEY_LF: begin
        for (int i = 0; i < line_len; i++) emit(KIND_LINE_CHR, line_mem[i], 0, line_len);
        emit(KIND_LINE_DONE, 8'h00, 0, line_len);
        record_line();
        clear_line();
      end
      KEY_BS, KEY_RUB: begin
        if (cur_pos != 0) begin
          cur_pos--;
          cut_char();
          redraw();
        end
      end
      CTL_UP:   run_final(FIN_UP);
      CTL_DOWN: run_final(FIN_DOWN);
      CTL_LEFT: begin
        csi_num = 0;
        run_final(FIN_LEFT);
      end
      CTL_RIGHT: begin
        csi_num = 0;
        run_final(FIN_RIGHT);
      end
      CTL_HOME: run_final(FIN_HOME);
      CTL_END:  run_final(FIN_END);
      KEY_DEL: begin
        if (cur_pos < line_len) begin
          cut_char();
          redraw();
        end
      end
      default: begin
        // printable (incl. 0x80..0xFF) inserts at the cursor unless the line is full
        if (c >= KEY_SPACE && line_len < LINE_BYTES - 1) begin
          for (int i = line_len; i > cur_pos; i--) line_mem[i] = line_mem[i - 1];
          line_mem[cur_pos] = c;
          line_len++;
          cur_pos++;
          redraw();
        end
      end
    endcase
  endfunction

  function automatic void model_reset();
    hist_en    = 1'b1;
    hist_slots = 4'd8;
    line_len   = 0;
    cur_pos    = 0;
    esc_st     = ESC_IDLE;
    csi_num    = 0;
    csi_digit  = 8'h00;
    ring_head  = 0;
    hist_cnt   = 0;
    walk_idx   = 0;
    walking    = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb_terminal_line_editor_history: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Key sender: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left, gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    if (!rst_ni) begin
      key_if.valid    <= 1'b0;
      key_if.key_byte <= 8'h00;
      burst_left      <= 0;
      gap_left        <= 0;
    end else begin
      nxt_valid = key_if.valid;
      nxt_byte  = key_if.key_byte;
      if (!key_if.valid || key_if.ready) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (key_q.size() != 0) begin
          nxt_valid = 1'b1;
          nxt_byte  = key_q.pop_front();
          if (burst_left <= 1) begin
            // some long bursts, otherwise short ones; the gap that follows is sometimes zero
            burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
      key_if.valid    <= nxt_valid;
      key_if.key_byte <= nxt_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: changing stall patterns plus two long hold-offs
  // ---------------------------------------------------------------------------
  int rx_mode, rx_mode_left, hold_left;

  always @(posedge clk_i or negedge rst_ni) begin
    logic rdy;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      rx_mode      <= 0;
      rx_mode_left <= 0;
      hold_left    <= 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(50, 400);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0:       rdy = 1'b1;
        1:       rdy = 1'($urandom_range(0, 1));
        2:       rdy = (cycles % 4 == 0);
        default: rdy = ($urandom_range(0, 9) != 0);
      endcase
      // long hold-offs so the editor backs up and drops key ready
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rdy = 1'b0;
      end else if (res_if.valid && res_if.ready && (words_rx == 400 || words_rx == 3000)) begin
        hold_left <= 800;
        rdy = 1'b0;
      end
      res_if.ready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitors: model each accepted key byte, check each accepted result word
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    row_t row;
    res_t got, want;
    if (rst_ni && key_if.valid && key_if.ready) begin
      words_out = 0;
      edit_byte(key_if.key_byte);
      if (words_out > 0) redraw_q[$].last = 1'b1;
      if (row_q.size() != 0) begin
        row = row_q.pop_front();
        if (row.nres >= 0 &&
            (words_out != row.nres ||
             (words_out > 0 && (redraw_q[$].kind != row.kind ||
                                redraw_q[$].len != row.len[5:0])))) begin
          $display("%0t: key %h expected %0d words ending kind %0d len %0d, model gives %0d",
                   $time, row.key, row.nres, row.kind, row.len, words_out);
          errors++;
        end
      end
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      words_rx++;
      got.kind = res_if.out_kind;
      got.chr  = res_if.out_char;
      got.back = res_if.cursor_back;
      got.len  = res_if.line_length;
      got.last = res_if.out_last;
      if (redraw_q.size() == 0) begin
        $display("%0t: unexpected word kind %0d char %h back %0d len %0d last %0d",
                 $time, got.kind, got.chr, got.back, got.len, got.last);
        errors++;
      end else begin
        want = redraw_q.pop_front();
        if (got != want) begin
          $display("%0t: expected kind %0d char %h back %0d len %0d last %0d",
                   $time, want.kind, want.chr, want.back, want.len, want.last);
          $display("%0t:   actual kind %0d char %h back %0d len %0d last %0d",
                   $time, got.kind, got.chr, got.back, got.len, got.last);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic wait_drained();
    while (key_q.size() != 0 || key_if.valid || redraw_q.size() != 0) @(posedge clk_i);
    // a history push may still run after the last word
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [0:0] idx, logic [3:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == CFG_HISTORY_ON) hist_en = val[0];
    else hist_slots = val;
    ring_head = 0;
    hist_cnt  = 0;
    walking   = 0;
    walk_idx  = 0;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void add_row(logic [7:0] k, int n, kind_e kd, int len);
    row_t r;
    r.key  = k;
    r.nres = n;
    r.kind = kd;
    r.len  = len;
    key_q.push_back(k);
    row_q.push_back(r);
  endfunction

  // CSI sequence: ESC [ up to three digits, then a final or a breaking byte
  function automatic void push_csi();
    logic [7:0] finals[7] = '{FIN_UP, FIN_DOWN, FIN_LEFT, FIN_RIGHT, FIN_HOME, FIN_END,
                              FIN_TILDE};
    key_q.push_back(KEY_ESC);
    key_q.push_back(KEY_LBRK);
    if ($urandom_range(0, 3) == 0) key_q.push_back(KEY_THREE);
    else repeat ($urandom_range(0, 3)) key_q.push_back(KEY_ZERO + 8'($urandom_range(0, 9)));
    case ($urandom_range(0, 9))
      0:       key_q.push_back(8'($urandom_range(FIN_LO, FIN_HI)));
      1:       key_q.push_back(8'($urandom_range(0, 8'h2F)));    // ends silently
      2:       key_q.push_back(8'($urandom_range(8'h7F, 8'hFF)));
      default: key_q.push_back(finals[$urandom_range(0, 6)]);
    endcase
  endfunction

  // queues random traffic until about n_bytes key bytes are waiting
  task automatic random_phase(int n_bytes);
    logic [7:0] edits[7] = '{KEY_BS, KEY_RUB, CTL_LEFT, CTL_RIGHT, CTL_HOME, CTL_END, KEY_DEL};
    int r;
    while (key_q.size() < n_bytes) begin
      r = $urandom_range(0, 99);
      if (r < 40)      key_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      else if (r < 43) key_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
      else if (r < 56) key_q.push_back(edits[$urandom_range(0, 6)]);
      else if (r < 68) push_csi();
      else if (r < 76) key_q.push_back($urandom_range(0, 1) ? CTL_UP : CTL_DOWN);
      else if (r < 85) key_q.push_back(KEY_LF);
      else if (r < 88) key_q.push_back(KEY_CTRL_C);
      else if (r < 92) begin
        key_q.push_back(KEY_ESC);
        key_q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 99) key_q.push_back(8'($urandom_range(0, 255)));
      else begin
        // long line, sometimes past the line limit
        repeat ($urandom_range(40, 70)) key_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
        key_q.push_back(KEY_LF);
      end
    end
  endtask

  initial begin
    errors   = 0;
    cycles   = 0;
    words_rx = 0;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_HISTORY_ON;
    cfg_data_i = 4'd0;
    model_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset state, every key but CTL_RIGHT, escape corner cases
    add_row(KEY_CTRL_C, 1, KIND_INTR, 0);
    add_row(KEY_LF, 1, KIND_LINE_DONE, 0);
    add_row(KEY_BS, 0, KIND_INTR, 0);
    add_row(CTL_LEFT, 0, KIND_INTR, 0);
    add_row(CTL_UP, 0, KIND_INTR, 0);
    add_row(KEY_SPACE, 2, KIND_REDRAW_END, 1);
    add_row(8'hFF, 3, KIND_REDRAW_END, 2);
    add_row(8'h7E, -1, KIND_INTR, 0);
    add_row(CTL_LEFT, -1, KIND_INTR, 0);
    add_row(CTL_HOME, -1, KIND_INTR, 0);
    add_row(KEY_DEL, -1, KIND_INTR, 0);
    add_row(CTL_END, -1, KIND_INTR, 0);
    add_row(KEY_RUB, -1, KIND_INTR, 0);
    add_row(KEY_ESC, 0, KIND_INTR, 0);
    add_row(8'h51, 0, KIND_INTR, 0);          // dropped after ESC
    add_row(KEY_ESC, 0, KIND_INTR, 0);
    add_row(KEY_LBRK, 0, KIND_INTR, 0);
    add_row(KEY_NINE, 0, KIND_INTR, 0);
    add_row(KEY_NINE, 0, KIND_INTR, 0);
    add_row(KEY_NINE, 0, KIND_INTR, 0);       // count saturates
    add_row(FIN_LEFT, -1, KIND_INTR, 0);
    add_row(KEY_ESC, 0, KIND_INTR, 0);
    add_row(KEY_LBRK, 0, KIND_INTR, 0);
    add_row(KEY_THREE, 0, KIND_INTR, 0);
    add_row(FIN_TILDE, -1, KIND_INTR, 0);     // delete by CSI
    add_row(8'h0D, 0, KIND_INTR, 0);          // CR is ignored
    add_row(KEY_LF, -1, KIND_INTR, 0);
    add_row(CTL_UP, -1, KIND_INTR, 0);
    add_row(CTL_DOWN, -1, KIND_INTR, 0);
    wait_drained();

    // random phases over several history settings, extremes included
    random_phase(RAND_ITEMS / 6);
    wait_drained();
    cfg_write(CFG_HISTORY_SLOTS, 4'd1);
    random_phase(RAND_ITEMS / 6);
    wait_drained();
    cfg_write(CFG_HISTORY_ON, 4'd0);
    random_phase(RAND_ITEMS / 8);
    wait_drained();
    cfg_write(CFG_HISTORY_ON, 4'd1);
    cfg_write(CFG_HISTORY_SLOTS, 4'd3);
    random_phase(RAND_ITEMS / 6);
    wait_drained();
    cfg_write(CFG_HISTORY_SLOTS, 4'd0);
    random_phase(RAND_ITEMS / 8);
    wait_drained();
    cfg_write(CFG_HISTORY_SLOTS, 4'd15);
    random_phase(RAND_ITEMS / 8);
    wait_drained();
    cfg_write(CFG_HISTORY_SLOTS, 4'd8);
    random_phase(RAND_ITEMS / 6);
    wait_drained();

    if (errors == 0) begin
      $display("tb_terminal_line_editor_history: clean");
    end else begin
      $display("tb_terminal_line_editor_history: errors");
    end
    $finish;
  end

endmodule
